// ===== hdl/cma_pkg.sv =====
// Shared types and constants of the offset-corrected current moving average.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package cma_pkg;

    // Sample and window geometry; the window length is a power of two
    localparam int SAMPLE_BITS = 12;
    localparam int WINDOW_LEN  = 16;
    localparam int WIN_SHIFT   = $clog2(WINDOW_LEN);
    localparam int SUM_BITS    = SAMPLE_BITS + WIN_SHIFT;
    localparam int CNT_BITS    = WIN_SHIFT;

    // Output buffer geometry
    localparam int OUT_DEPTH    = 2;
    localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    // Sample tag codes
    localparam logic MODE_CALIB = 1'b0;
    localparam logic MODE_MEAS  = 1'b1;

    typedef logic [SAMPLE_BITS-1:0]  sample_t;
    typedef logic [SUM_BITS-1:0]     sum_t;
    typedef logic [CNT_BITS-1:0]     cnt_t;
    typedef logic [OUT_PTR_BITS-1:0] out_ptr_t;
    typedef logic [OUT_CNT_BITS-1:0] out_cnt_t;

    localparam cnt_t CNT_LAST = cnt_t'(WINDOW_LEN - 1);

    // Control of the window cell row
    typedef struct packed {
        logic shift;    // take a new measurement word, oldest drops out
        logic clear;    // zero every cell and the running sum
    } win_ctl_t;

    // One result word as held in the output buffer
    typedef struct packed {
        sample_t current_value;
        sample_t window_mean;
        sample_t zero_offset;
        logic    calibration_done;
    } result_t;

endpackage

// ===== hdl/cma_in_if.sv =====
// Input channel of the current moving average: valid/ready plus one sample word.
// Depends on cma_pkg.
`timescale 1ns / 1ps

interface cma_in_if;
    import cma_pkg::*;

    logic    valid;
    logic    ready;
    logic    mode;
    sample_t sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

// ===== hdl/cma_out_if.sv =====
// Output channel of the current moving average: valid/ready plus one result word.
// Depends on cma_pkg.
`timescale 1ns / 1ps

interface cma_out_if;
    import cma_pkg::*;

    logic    valid;
    logic    ready;
    sample_t current_value;
    sample_t window_mean;
    sample_t zero_offset;
    logic    calibration_done;

    modport source (output valid, output current_value, output window_mean,
                    output zero_offset, output calibration_done, input ready);
    modport sink   (input valid, input current_value, input window_mean,
                    input zero_offset, input calibration_done, output ready);
endinterface

// ===== hdl/cma_cell.sv =====
// One cell of the sample window: holds one measurement word, passes it on.
// Depends on cma_pkg.
`timescale 1ns / 1ps

module cma_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  cma_pkg::win_ctl_t ctl,
    input  cma_pkg::sample_t  d,
    output cma_pkg::sample_t  q
);
    import cma_pkg::*;

    sample_t data_reg;
    sample_t data_next;

    // Clear wins over shift; otherwise hold
    always_comb
    begin
        data_next = data_reg;
        if (ctl.clear)
        begin
            data_next = '0;
        end
        else if (ctl.shift)
        begin
            data_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

// ===== hdl/cma_window.sv =====
// Sliding sample window: a row of cma_cell stages and the running sum over them.
// Depends on cma_pkg and cma_cell.
`timescale 1ns / 1ps

module cma_window (
    input  logic              clk,
    input  logic              rst_n,
    input  cma_pkg::win_ctl_t ctl,
    input  cma_pkg::sample_t  sample,
    output cma_pkg::sample_t  mean_cur,
    output cma_pkg::sample_t  mean_upd
);
    import cma_pkg::*;

    sample_t tap [WINDOW_LEN];
    sum_t    sum_reg;
    sum_t    sum_upd;
    sum_t    sum_next;

    // Build the cell row; cell 0 takes the new word, the last holds the oldest
    for (genvar i = 0; i < WINDOW_LEN; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            cma_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .d     (sample),
                .q     (tap[i])
            );
        end
        else
        begin : g_body
            cma_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (ctl),
                .d     (tap[i-1]),
                .q     (tap[i])
            );
        end
    end

    // Running sum: add the new word, drop the oldest
    assign sum_upd = sum_reg
                   - {{(SUM_BITS-SAMPLE_BITS){1'b0}}, tap[WINDOW_LEN-1]}
                   + {{(SUM_BITS-SAMPLE_BITS){1'b0}}, sample};

    always_comb
    begin
        sum_next = sum_reg;
        if (ctl.clear)
        begin
            sum_next = '0;
        end
        else if (ctl.shift)
        begin
            sum_next = sum_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    // Mean is the sum divided by the window length (shifted down by WIN_SHIFT)
    assign mean_cur = sum_reg[SUM_BITS-1:WIN_SHIFT];
    assign mean_upd = sum_upd[SUM_BITS-1:WIN_SHIFT];

endmodule

// ===== hdl/cma_calib.sv =====
// Zero-offset calibration: sums a full window of calibration words, sets the offset.
// Depends on cma_pkg.
`timescale 1ns / 1ps

module cma_calib (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             acc,
    input  logic             drop,
    input  cma_pkg::sample_t sample,
    output logic             done,
    output cma_pkg::sample_t offset_cur,
    output cma_pkg::sample_t offset_next
);
    import cma_pkg::*;

    sum_t    calib_sum_reg;
    sum_t    calib_sum_next;
    sum_t    sum_add;
    cnt_t    calib_count_reg;
    cnt_t    calib_count_next;
    sample_t offset_reg;

    assign sum_add = calib_sum_reg + {{(SUM_BITS-SAMPLE_BITS){1'b0}}, sample};
    assign done    = acc && (calib_count_reg == CNT_LAST);

    // Accumulate; restart after a full window or on a measurement word
    always_comb
    begin
        calib_sum_next   = calib_sum_reg;
        calib_count_next = calib_count_reg;
        offset_next      = offset_reg;
        if (done || drop)
        begin
            calib_sum_next   = '0;
            calib_count_next = '0;
        end
        else if (acc)
        begin
            calib_sum_next   = sum_add;
            calib_count_next = calib_count_reg + cnt_t'(1);
        end
        if (done)
        begin
            offset_next = sum_add[SUM_BITS-1:WIN_SHIFT];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_sum_reg   <= '0;
            calib_count_reg <= '0;
            offset_reg      <= '0;
        end
        else
        begin
            calib_sum_reg   <= calib_sum_next;
            calib_count_reg <= calib_count_next;
            offset_reg      <= offset_next;
        end
    end

    assign offset_cur = offset_reg;

endmodule

// ===== hdl/current_offset_moving_average.sv =====
// Top level of the offset-corrected current moving average.
// Depends on cma_pkg, cma_in_if, cma_out_if, cma_window and cma_calib.
//
// Each accepted sample word yields exactly one result word.
// The block takes one word every cycle unless stalled: the window update is
// a single add-and-subtract on the running sum beside a row of 16 cells that
// shift by one on each measurement word, and the result lands in a two-word
// output buffer. in_ch.ready drops only while both words wait for the sink.
// Calibration words (mode 0) are summed; the sixteenth sets the zero offset to
// their mean, flags calibration_done and empties the window. A measurement
// word (mode 1) cancels a partial calibration. No reset sweep is needed.
`timescale 1ns / 1ps

module current_offset_moving_average (
    input  logic     clk,
    input  logic     rst_n,
    cma_in_if.sink   in_ch,
    cma_out_if.source out_ch
);
    import cma_pkg::*;

    logic     accept;
    logic     pop;
    logic     calib_acc;
    logic     meas_acc;
    logic     calib_done;
    win_ctl_t win_ctl;
    sample_t  mean_cur;
    sample_t  mean_upd;
    sample_t  offset_cur;
    sample_t  offset_next;
    sample_t  current_upd;
    sample_t  last_current_reg;
    sample_t  last_current_next;
    result_t  result;

    result_t  slot_reg [OUT_DEPTH];
    out_ptr_t wr_ptr_reg;
    out_ptr_t rd_ptr_reg;
    out_cnt_t count_reg;
    out_cnt_t count_next;

    // Handshake
    assign accept    = in_ch.valid && in_ch.ready;
    assign pop       = out_ch.valid && out_ch.ready;
    assign calib_acc = accept && (in_ch.mode == MODE_CALIB);
    assign meas_acc  = accept && (in_ch.mode == MODE_MEAS);

    cma_calib u_calib (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (calib_acc),
        .drop        (meas_acc),
        .sample      (in_ch.sample),
        .done        (calib_done),
        .offset_cur  (offset_cur),
        .offset_next (offset_next)
    );

    assign win_ctl.shift = meas_acc;
    assign win_ctl.clear = calib_done;

    cma_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (win_ctl),
        .sample   (in_ch.sample),
        .mean_cur (mean_cur),
        .mean_upd (mean_upd)
    );

    // Remove the offset, floor at zero
    assign current_upd = (mean_upd > offset_cur) ? (mean_upd - offset_cur) : '0;
    assign last_current_next = meas_acc ? current_upd : last_current_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_current_reg <= '0;
        end
        else
        begin
            last_current_reg <= last_current_next;
        end
    end

    // Assemble the result word
    always_comb
    begin
        result.current_value    = last_current_next;
        result.zero_offset      = offset_next;
        result.calibration_done = calib_done;
        if (meas_acc)
        begin
            result.window_mean = mean_upd;
        end
        else if (calib_done)
        begin
            result.window_mean = '0;
        end
        else
        begin
            result.window_mean = mean_cur;
        end
    end

    // Output buffer: push on accept, pop on sink handshake
    assign count_next = count_reg + out_cnt_t'(accept) - out_cnt_t'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + out_ptr_t'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + out_ptr_t'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg[wr_ptr_reg] <= result;
        end
    end

    // Drive the channels
    assign in_ch.ready              = (count_reg != out_cnt_t'(OUT_DEPTH));
    assign out_ch.valid             = (count_reg != '0);
    assign out_ch.current_value     = slot_reg[rd_ptr_reg].current_value;
    assign out_ch.window_mean       = slot_reg[rd_ptr_reg].window_mean;
    assign out_ch.zero_offset       = slot_reg[rd_ptr_reg].zero_offset;
    assign out_ch.calibration_done  = slot_reg[rd_ptr_reg].calibration_done;

endmodule

// ===== hdl/cma_checker.sv =====
// Port-level checks of the current moving average, bound to the top level.
// Depends on cma_pkg and current_offset_moving_average.
`timescale 1ns / 1ps

module cma_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input cma_pkg::sample_t current_value,
    input cma_pkg::sample_t window_mean,
    input cma_pkg::sample_t zero_offset,
    input logic             calibration_done
);
    import cma_pkg::*;

    // A waiting word stays offered until taken
    a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word withdrawn before it was taken");

    // A stalled word keeps its payload
    a_out_stable : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(current_value) && $stable(window_mean)
                                    && $stable(zero_offset) && $stable(calibration_done))
        else $error("output word changed while stalled");

    // Input stalls only while the output buffer holds words
    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    // The window is emptied when calibration completes
    a_done_empty : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && calibration_done |-> window_mean == '0)
        else $error("window not cleared at end of calibration");

endmodule

bind current_offset_moving_average cma_checker u_cma_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .current_value    (out_ch.current_value),
    .window_mean      (out_ch.window_mean),
    .zero_offset      (out_ch.zero_offset),
    .calibration_done (out_ch.calibration_done)
);

// ===== tb/sv/tb_current_offset_moving_average.sv =====
// Self-checking testbench of current_offset_moving_average: directed and random sample words,
// with a built-in offset/moving-average predictor. Random idling on both sides.
// Depends on cma_pkg, cma_in_if, cma_out_if and the block's RTL.
`timescale 1ns / 1ps

module tb_current_offset_moving_average;
    import cma_pkg::*;

    localparam int TOTAL_WORDS    = 650;
    localparam int MAX_IDLE       = 18;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 10;
    localparam sample_t FULL_SCALE = sample_t'((1 << SAMPLE_BITS) - 1);

    // Predicts the result word of every accepted sample word and checks the
    // words the block returns against them, oldest first.
    class current_average_scoreboard;
        sample_t window_cells[WINDOW_LEN];
        sum_t    running_sum;
        cnt_t    next_cell;
        sum_t    calib_total;
        logic [CNT_BITS:0] calib_seen;
        sample_t offset;
        sample_t held_current;
        result_t expected_results[$];
        int words_seen;
        int calib_words;
        int meas_words;
        int calibrations;
        int interrupted;
        int results_checked;
        int failures;
        int reported;

        function new();
            clear_window();
            calib_total     = '0;
            calib_seen      = '0;
            offset          = '0;
            held_current    = '0;
            words_seen      = 0;
            calib_words     = 0;
            meas_words      = 0;
            calibrations    = 0;
            interrupted     = 0;
            results_checked = 0;
            failures        = 0;
            reported        = 0;
        endfunction

        function void clear_window();
            foreach (window_cells[i])
                window_cells[i] = '0;
            running_sum = '0;
            next_cell   = '0;
        endfunction

        // Advance the predicted state by one accepted sample word
        function void note_sample(logic mode, sample_t sample);
            result_t want;
            want.calibration_done = 1'b0;
            words_seen++;
            if (mode == MODE_CALIB)
            begin
                calib_words++;
                calib_total = calib_total + sum_t'(sample);
                calib_seen  = calib_seen + 1'b1;
                // sixteenth word: take the mean as offset, empty the window
                if (calib_seen >= WINDOW_LEN)
                begin
                    offset      = sample_t'(calib_total >> WIN_SHIFT);
                    calib_total = '0;
                    calib_seen  = '0;
                    clear_window();
                    want.calibration_done = 1'b1;
                    calibrations++;
                end
            end
            else
            begin
                meas_words++;
                // a measurement word drops any partial calibration
                if (calib_seen != 0)
                    interrupted++;
                calib_total = '0;
                calib_seen  = '0;
                running_sum = running_sum - sum_t'(window_cells[next_cell]) + sum_t'(sample);
                window_cells[next_cell] = sample;
                next_cell = next_cell + 1'b1;
                if (sample_t'(running_sum >> WIN_SHIFT) <= offset)
                    held_current = '0;
                else
                    held_current = sample_t'(running_sum >> WIN_SHIFT) - offset;
            end
            want.current_value = held_current;
            want.window_mean   = sample_t'(running_sum >> WIN_SHIFT);
            want.zero_offset   = offset;
            expected_results.push_back(want);
        endfunction

        // Compare one accepted result word with the oldest prediction
        function void check_result(sample_t current_value, sample_t window_mean,
                                   sample_t zero_offset, logic calibration_done);
            result_t want;
            if (expected_results.size() == 0)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("unexpected result word: cur=%0d mean=%0d off=%0d done=%0b",
                             current_value, window_mean, zero_offset, calibration_done);
                end
                return;
            end
            want = expected_results.pop_front();
            results_checked++;
            if (want.current_value !== current_value || want.window_mean !== window_mean ||
                want.zero_offset !== zero_offset ||
                want.calibration_done !== calibration_done)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("result word %0d mismatch: expected cur=%0d mean=%0d off=%0d done=%0b",
                             results_checked, want.current_value, want.window_mean,
                             want.zero_offset, want.calibration_done);
                    $display("    got cur=%0d mean=%0d off=%0d done=%0b",
                             current_value, window_mean, zero_offset, calibration_done);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Anything still predicted at the end never came out
        function void close_out();
            if (expected_results.size() != 0)
            begin
                failures += expected_results.size();
                $display("%0d expected result words never arrived", expected_results.size());
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic source_idle_on;
    logic sink_idle_on;
    current_average_scoreboard board;

    cma_in_if  in_ch ();
    cma_out_if out_ch ();

    current_offset_moving_average u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one sample word after a random gap; return at the falling edge
    // after it was taken, with valid still high.
    task automatic send_word(logic mode, sample_t sample);
        int gap;
        gap = source_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= mode;
        in_ch.sample <= sample;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_sample(mode, sample);
        @(negedge clk);
    endtask

    // Hold the sender until every predicted result word has come back
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    function automatic sample_t pick_level();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FULL_SCALE;
            default: return sample_t'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    // Random sample around a level, clamped to the ADC range
    function automatic sample_t near(sample_t level, int spread);
        int v;
        v = int'(level) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        return sample_t'(v);
    endfunction

    task automatic run_directed();
        int i;
        source_idle_on = 1'b0;
        // partial calibration, then cut short by measurement words
        send_word(MODE_CALIB, FULL_SCALE);
        send_word(MODE_CALIB, '0);
        send_word(MODE_CALIB, FULL_SCALE);
        send_word(MODE_MEAS, FULL_SCALE);
        send_word(MODE_MEAS, '0);
        // full calibration of alternating extremes, offset lands mid-scale
        source_idle_on = 1'b1;
        for (i = 0; i < WINDOW_LEN; i++)
            send_word(MODE_CALIB, (i % 2 == 0) ? FULL_SCALE : sample_t'(0));
        // fresh window stays below the offset
        send_word(MODE_MEAS, FULL_SCALE);
        send_word(MODE_MEAS, FULL_SCALE);
        send_word(MODE_MEAS, '0);
    endtask

    task automatic run_random();
        int kind;
        int len;
        int spread;
        sample_t level;
        while (board.words_seen < TOTAL_WORDS)
        begin
            source_idle_on = ($urandom_range(0, 3) != 0);
            kind   = $urandom_range(0, 9);
            level  = pick_level();
            spread = $urandom_range(0, 1) ? int'($urandom_range(0, 40))
                                          : int'($urandom_range(0, FULL_SCALE));
            if (kind <= 2)
            begin
                // complete calibration
                repeat (WINDOW_LEN) send_word(MODE_CALIB, near(level, spread));
            end
            else if (kind <= 6)
            begin
                // run of measurement words
                len = $urandom_range(1, 48);
                repeat (len) send_word(MODE_MEAS, near(level, spread));
            end
            else if (kind <= 8)
            begin
                // calibration broken off by a measurement word
                len = $urandom_range(1, WINDOW_LEN - 1);
                repeat (len) send_word(MODE_CALIB, near(level, spread));
                send_word(MODE_MEAS, near(level, spread));
            end
            else
            begin
                // noise: random tags and full-range samples
                len = $urandom_range(1, 8);
                repeat (len)
                    send_word(logic'($urandom_range(0, 1)),
                              sample_t'($urandom_range(0, FULL_SCALE)));
            end
            if ($urandom_range(0, 14) == 0)
                wait_for_drain();
        end
    endtask

    // Result sink: random stalls, check every word taken
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = sink_idle_on ? int'($urandom_range(0, MAX_IDLE)) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
            board.check_result(out_ch.current_value, out_ch.window_mean,
                               out_ch.zero_offset, out_ch.calibration_done);
            if ($urandom_range(0, 31) == 0)
                sink_idle_on = ~sink_idle_on;
            @(negedge clk);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Main sequence
    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_CALIB;
        in_ch.sample   = '0;
        out_ch.ready   = 1'b0;
        rst_n          = 1'b0;
        source_idle_on = 1'b0;
        sink_idle_on   = 1'b1;
        board = new();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();
        wait_for_drain();
        run_random();
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        board.close_out();

        $display("Run covered %0d sample words (%0d calibration, %0d measurement),",
                 board.words_seen, board.calib_words, board.meas_words);
        $display("%0d results checked, %0d calibrations completed, %0d cut short.",
                 board.results_checked, board.calibrations, board.interrupted);
        if (board.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/cma_pkg.sv
hdl/cma_in_if.sv
hdl/cma_out_if.sv
hdl/cma_cell.sv
hdl/cma_window.sv
hdl/cma_calib.sv
hdl/current_offset_moving_average.sv
hdl/cma_checker.sv
tb/sv/tb_current_offset_moving_average.sv
